FILE: rtl/mtam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtam_pkg
// Shared types, register codes and reset values of the tone modulator core.
// ----------------------------------------------------------------------------
package mtam_pkg;

  localparam int MTAM_TABLE_DEPTH = 64;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int ENTRY_IDX_W = 6;
  localparam int PITCH_W     = 16;
  localparam int LENGTH_W    = 8;
  localparam int DUTY_W      = 8;
  localparam int TONE_PRE_W  = 11;
  localparam int BEAT_PER_W  = 18;
  localparam int SONG_LEN_W  = 7;

  localparam logic [DUTY_W-1:0]     CARRIER_TOP_RST = 8'd13;
  localparam logic [DUTY_W-1:0]     REST_DUTY_RST   = 8'd1;
  localparam logic [DUTY_W-1:0]     TOGGLE_MASK_RST = 8'd6;
  localparam logic [TONE_PRE_W-1:0] TONE_PRE_RST    = 11'd64;
  localparam logic [BEAT_PER_W-1:0] BEAT_PER_RST    = 18'd65536;
  localparam logic [SONG_LEN_W-1:0] SONG_LEN_RST    = 7'd34;

  localparam logic [TONE_PRE_W-1:0] TONE_PRE_MAX    = 11'd1024;
  localparam logic [BEAT_PER_W-1:0] BEAT_PER_MAX    = 18'd131072;

  localparam logic [DUTY_W-1:0]   DUTY_RST      = 8'd1;
  localparam logic [PITCH_W-1:0]  TONE_TOP_RST  = 16'd1;
  localparam logic [LENGTH_W-1:0] BEATS_RST     = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_TOP = 3'd0,
    CFG_REST_DUTY   = 3'd1,
    CFG_TOGGLE_MASK = 3'd2,
    CFG_TONE_PRE    = 3'd3,
    CFG_BEAT_PER    = 3'd4,
    CFG_SONG_LEN    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [DUTY_W-1:0]     carrier_top;
    logic [DUTY_W-1:0]     rest_duty;
    logic [DUTY_W-1:0]     toggle_mask;
    logic [TONE_PRE_W-1:0] tone_prescale;
    logic [BEAT_PER_W-1:0] beat_period;
    logic [SONG_LEN_W-1:0] song_length;
  } cfg_t;

  typedef struct packed {
    logic [PITCH_W-1:0]  pitch;
    logic [LENGTH_W-1:0] length;
  } note_entry_t;

  typedef struct packed {
    logic                   carrier_out;
    logic [ENTRY_IDX_W-1:0] playing_index;
    logic                   tone_active;
    logic [DUTY_W-1:0]      duty_now;
  } status_t;

endpackage

FILE: rtl/melody_tone_am_modulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_tone_am_modulator_core
// Square-wave melody player on an inverted fast-PWM carrier.
// ----------------------------------------------------------------------------
// Every input beat is either one system clock tick (mode 0) or a write of one
// melody table entry (mode 1), and every input beat yields exactly one result
// beat showing the carrier level, note index, tone-active flag and duty as
// they stood before that beat took effect. One beat is taken per clock cycle
// unless in_stall is high: the whole tick is a single registered pass through
// the carrier, tone and beat logic, and the table entry for the next note is
// read ahead of time from the melody memory so a note change never holds off
// a beat. Results sit in one output register; a new beat is taken whenever
// that register is empty or is being drained in the same cycle. Load the
// table before ticking; entries never written read back as undefined values.
module melody_tone_am_modulator_core
  import mtam_pkg::*;
#(
  parameter int TABLE_DEPTH = MTAM_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [PITCH_W-1:0]     in_entry_pitch,
  input  logic [LENGTH_W-1:0]    in_entry_length,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_carrier_out,
  output logic [ENTRY_IDX_W-1:0] out_playing_index,
  output logic                   out_tone_active,
  output logic [DUTY_W-1:0]      out_duty_now,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t                  cfg;
  logic [SONG_LEN_W-1:0] song_len_nxt;
  note_entry_t           wr_entry;
  note_entry_t           next_entry;
  logic [AW-1:0]         prefetch_addr;
  status_t               status;
  status_t               out_r;
  logic                  out_valid_r;
  logic                  in_accept;
  logic                  wr_en;
  logic [AW+ENTRY_IDX_W-1:0] idx_ext;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign idx_ext  = {{AW{1'b0}}, in_entry_index};
  assign wr_en    = in_accept && in_mode && (idx_ext < (AW+ENTRY_IDX_W)'(TABLE_DEPTH));
  assign wr_entry = '{pitch: in_entry_pitch, length: in_entry_length};

  mtam_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .song_len_nxt (song_len_nxt)
  );

  mtam_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (idx_ext[AW-1:0]),
    .wr_entry (wr_entry),
    .rd_addr  (prefetch_addr),
    .rd_entry (next_entry)
  );

  mtam_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (in_accept && !in_mode),
    .cfg           (cfg),
    .song_len_nxt  (song_len_nxt),
    .next_entry    (next_entry),
    .prefetch_addr (prefetch_addr),
    .status        (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_carrier_out   = out_r.carrier_out;
  assign out_playing_index = out_r.playing_index;
  assign out_tone_active   = out_r.tone_active;
  assign out_duty_now      = out_r.duty_now;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(in_valid && !in_stall)) |=> !out_valid)
    else $error("result repeated after drain");

endmodule

FILE: rtl/mtam_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtam_cfg_regs
// Configuration register file, written one beat at a time.
// ----------------------------------------------------------------------------
module mtam_cfg_regs
  import mtam_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg,
  output logic [SONG_LEN_W-1:0]  song_len_nxt
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready    = 1'b1;
  assign cfg          = cfg_r;
  assign song_len_nxt = cfg_nxt.song_length;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CARRIER_TOP: cfg_nxt.carrier_top   = cfg_data[DUTY_W-1:0];
        CFG_REST_DUTY:   cfg_nxt.rest_duty     = cfg_data[DUTY_W-1:0];
        CFG_TOGGLE_MASK: cfg_nxt.toggle_mask   = cfg_data[DUTY_W-1:0];
        CFG_TONE_PRE:    cfg_nxt.tone_prescale = cfg_data[TONE_PRE_W-1:0];
        CFG_BEAT_PER:    cfg_nxt.beat_period   = cfg_data[BEAT_PER_W-1:0];
        CFG_SONG_LEN:    cfg_nxt.song_length   = cfg_data[SONG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_top   <= CARRIER_TOP_RST;
      cfg_r.rest_duty     <= REST_DUTY_RST;
      cfg_r.toggle_mask   <= TOGGLE_MASK_RST;
      cfg_r.tone_prescale <= TONE_PRE_RST;
      cfg_r.beat_period   <= BEAT_PER_RST;
      cfg_r.song_length   <= SONG_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/mtam_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtam_table
// Melody table memory with one write port and a registered prefetch read.
// ----------------------------------------------------------------------------
module mtam_table
  import mtam_pkg::*;
#(
  parameter int TABLE_DEPTH = MTAM_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  note_entry_t                    wr_entry,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output note_entry_t                    rd_entry
);

  note_entry_t mem [TABLE_DEPTH];
  note_entry_t rd_r;

  assign rd_entry = rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // same-cycle write to the prefetched entry is forwarded
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_r <= wr_entry;
    end else begin
      rd_r <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/mtam_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtam_engine
// Carrier counter, prescaled tone counter and beat sequencer, one tick a beat.
// ----------------------------------------------------------------------------
module mtam_engine
  import mtam_pkg::*;
#(
  parameter int TABLE_DEPTH = MTAM_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  cfg_t                           cfg,
  input  logic [SONG_LEN_W-1:0]          song_len_nxt,
  input  note_entry_t                    next_entry,
  output logic [$clog2(TABLE_DEPTH)-1:0] prefetch_addr,
  output status_t                        status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = ((AW + 1) > SONG_LEN_W) ? (AW + 1) : SONG_LEN_W;

  function automatic logic [AW-1:0] step_pos(input logic [AW-1:0] pos,
                                             input logic first,
                                             input logic [SONG_LEN_W-1:0] slen);
    logic [CW-1:0] len;
    logic [CW-1:0] cand;
    if (slen == '0) begin
      len = CW'(1);
    end else if (CW'(slen) > CW'(TABLE_DEPTH)) begin
      len = CW'(TABLE_DEPTH);
    end else begin
      len = CW'(slen);
    end
    cand = first ? '0 : (CW'(pos) + CW'(1));
    if (cand >= len) begin
      cand = '0;
    end
    return cand[AW-1:0];
  endfunction

  logic [DUTY_W-1:0]     carrier_count_r, carrier_count_nxt;
  logic [DUTY_W-1:0]     duty_pending_r, duty_pending_nxt;
  logic [DUTY_W-1:0]     duty_active_r, duty_active_nxt;
  logic [TONE_PRE_W-2:0] tone_pre_r, tone_pre_nxt;
  logic [PITCH_W-1:0]    tone_count_r, tone_count_nxt;
  logic [PITCH_W-1:0]    tone_top_r, tone_top_nxt;
  logic [BEAT_PER_W-2:0] beat_pre_r, beat_pre_nxt;
  logic [AW-1:0]         note_pos_r, note_pos_nxt;
  logic                  first_r, first_nxt;
  logic [LENGTH_W-1:0]   beats_left_r, beats_left_nxt;
  logic [PITCH_W-1:0]    cur_tone_r, cur_tone_nxt;

  logic [TONE_PRE_W-1:0] tone_lim;
  logic [BEAT_PER_W-1:0] beat_lim;
  logic                  tone_hit;
  logic                  beat_hit;
  logic [LENGTH_W-1:0]   beats_dec;
  logic [AW-1:0]         load_pos;
  logic [AW+ENTRY_IDX_W-1:0] pos_ext;

  always_comb begin
    if (cfg.tone_prescale == '0) begin
      tone_lim = TONE_PRE_W'(1);
    end else if (cfg.tone_prescale > TONE_PRE_MAX) begin
      tone_lim = TONE_PRE_MAX;
    end else begin
      tone_lim = cfg.tone_prescale;
    end
    if (cfg.beat_period == '0) begin
      beat_lim = BEAT_PER_W'(1);
    end else if (cfg.beat_period > BEAT_PER_MAX) begin
      beat_lim = BEAT_PER_MAX;
    end else begin
      beat_lim = cfg.beat_period;
    end
  end

  assign tone_hit  = ({1'b0, tone_pre_r} + TONE_PRE_W'(1)) >= tone_lim;
  assign beat_hit  = ({1'b0, beat_pre_r} + BEAT_PER_W'(1)) >= beat_lim;
  assign beats_dec = beats_left_r - LENGTH_W'(1);
  assign load_pos  = step_pos(note_pos_r, first_r, cfg.song_length);

  always_comb begin
    carrier_count_nxt = carrier_count_r;
    duty_pending_nxt  = duty_pending_r;
    duty_active_nxt   = duty_active_r;
    tone_pre_nxt      = tone_pre_r;
    tone_count_nxt    = tone_count_r;
    tone_top_nxt      = tone_top_r;
    beat_pre_nxt      = beat_pre_r;
    note_pos_nxt      = note_pos_r;
    first_nxt         = first_r;
    beats_left_nxt    = beats_left_r;
    cur_tone_nxt      = cur_tone_r;
    if (tick) begin
      // carrier
      if (carrier_count_r >= cfg.carrier_top) begin
        carrier_count_nxt = '0;
        duty_active_nxt   = duty_pending_r;
      end else begin
        carrier_count_nxt = carrier_count_r + DUTY_W'(1);
      end
      // tone counter
      if (tone_hit) begin
        tone_pre_nxt = '0;
        if (tone_count_r == tone_top_r) begin
          tone_count_nxt   = '0;
          duty_pending_nxt = (cur_tone_r != '0) ? (duty_pending_r ^ cfg.toggle_mask)
                                                : cfg.rest_duty;
        end else begin
          tone_count_nxt = tone_count_r + PITCH_W'(1);
        end
      end else begin
        tone_pre_nxt = tone_pre_r + (TONE_PRE_W-1)'(1);
      end
      // beat sequencer, a note load with a nonzero pitch wins over the tone count step
      if (beat_hit) begin
        beat_pre_nxt   = '0;
        beats_left_nxt = beats_dec;
        if (beats_dec == '0) begin
          note_pos_nxt   = load_pos;
          first_nxt      = 1'b0;
          cur_tone_nxt   = next_entry.pitch;
          beats_left_nxt = next_entry.length;
          if (next_entry.pitch != '0) begin
            tone_count_nxt = '0;
            tone_top_nxt   = next_entry.pitch;
          end
        end
      end else begin
        beat_pre_nxt = beat_pre_r + (BEAT_PER_W-1)'(1);
      end
    end
  end

  assign prefetch_addr = step_pos(note_pos_nxt, first_nxt, song_len_nxt);

  assign pos_ext = {{ENTRY_IDX_W{1'b0}}, note_pos_r};

  always_comb begin
    status.carrier_out   = carrier_count_r > duty_active_r;
    status.playing_index = first_r ? '1 : pos_ext[ENTRY_IDX_W-1:0];
    status.tone_active   = cur_tone_r != '0;
    status.duty_now      = duty_active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_count_r <= '0;
      duty_pending_r  <= DUTY_RST;
      duty_active_r   <= DUTY_RST;
      tone_pre_r      <= '0;
      tone_count_r    <= '0;
      tone_top_r      <= TONE_TOP_RST;
      beat_pre_r      <= '0;
      note_pos_r      <= '0;
      first_r         <= 1'b1;
      beats_left_r    <= BEATS_RST;
      cur_tone_r      <= '0;
    end else begin
      carrier_count_r <= carrier_count_nxt;
      duty_pending_r  <= duty_pending_nxt;
      duty_active_r   <= duty_active_nxt;
      tone_pre_r      <= tone_pre_nxt;
      tone_count_r    <= tone_count_nxt;
      tone_top_r      <= tone_top_nxt;
      beat_pre_r      <= beat_pre_nxt;
      note_pos_r      <= note_pos_nxt;
      first_r         <= first_nxt;
      beats_left_r    <= beats_left_nxt;
      cur_tone_r      <= cur_tone_nxt;
    end
  end

endmodule
